/* design/fqrc_pkg.sv */
// Shared types, constants and codes for the frame QP rate controller.
`default_nettype none
package fqrc_pkg;

    // Width of the shared add/subtract unit; holds 13 * 2^40 with margin.
    localparam int ALU_W = 46;

    // Configuration register indexes.
    localparam logic [2:0] CFG_RC_MODE      = 3'd0;
    localparam logic [2:0] CFG_BUCKET_SIZE  = 3'd1;
    localparam logic [2:0] CFG_FRAME_BUDGET = 3'd2;
    localparam logic [2:0] CFG_START_QP     = 3'd3;
    localparam logic [2:0] CFG_LOWEST_QP    = 3'd4;
    localparam logic [2:0] CFG_HIGHEST_QP   = 3'd5;

    // Rate control modes.
    localparam logic [1:0] MODE_CBR     = 2'd0;
    localparam logic [1:0] MODE_VBR     = 2'd1;
    localparam logic [1:0] MODE_LOW_LAT = 2'd2;

    // Input operations.
    localparam logic OP_REQ_QP      = 1'b0;
    localparam logic OP_REPORT_BITS = 1'b1;

    // Reset values.
    localparam logic [1:0]  RST_RC_MODE      = MODE_CBR;
    localparam logic [31:0] RST_BUCKET_SIZE  = 32'd5000000;
    localparam logic [31:0] RST_FRAME_BUDGET = 32'd83333;
    localparam logic [5:0]  RST_START_QP     = 6'd26;
    localparam logic [5:0]  RST_LOWEST_QP    = 6'd12;
    localparam logic [5:0]  RST_HIGHEST_QP   = 6'd51;
    localparam logic [31:0] RST_FULLNESS     = 32'd2500000;
    localparam logic [5:0]  RST_QP           = 6'd26;

    // Step limits toward the target QP.
    localparam logic signed [10:0] STEP_NORMAL  = 11'sd2;
    localparam logic signed [10:0] STEP_LOW_LAT = 11'sd3;

    typedef struct packed {
        logic [1:0]  rc_mode;
        logic [31:0] bucket_size;
        logic [31:0] frame_budget;
        logic [5:0]  start_qp;
        logic [5:0]  lowest_qp;
        logic [5:0]  highest_qp;
    } t_cfg;

    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             ge;   // carry out; on subtract, a >= b
    } t_alu_rsp;

endpackage
`default_nettype wire

/* design/fqrc_alu.sv */
// Shared add/subtract unit with carry out, reused by the sequencer's arithmetic steps.
`default_nettype none
module fqrc_alu
    import fqrc_pkg::*;
(
    input  var t_alu_req i_req,
    output t_alu_rsp     o_rsp
);

    logic [ALU_W:0]   w_full;
    logic [ALU_W-1:0] w_b;

    assign w_b    = i_req.b ^ {ALU_W{i_req.sub}};
    assign w_full = {1'b0, i_req.a} + {1'b0, w_b} + (ALU_W+1)'(i_req.sub);

    assign o_rsp.sum = w_full[ALU_W-1:0];
    assign o_rsp.ge  = w_full[ALU_W];

endmodule
`default_nettype wire

/* design/fqrc_core.sv */
// Sequencer and state of the rate controller; drives the shared ALU step by step.
`default_nettype none
module fqrc_core
    import fqrc_pkg::*;
(
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var t_cfg        i_cfg,
    input  var logic        i_reload,
    input  var logic [31:0] i_reload_level,
    input  var logic        i_in_valid,
    output logic            o_in_ready,
    input  var logic        i_op,
    input  var logic [39:0] i_sad,
    input  var logic [31:0] i_bits,
    output logic            o_res_valid,
    input  var logic        i_res_ready,
    output logic [5:0]      o_qp,
    output logic [31:0]     o_level
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_ERR   = 5'd1;
    localparam logic [4:0] ST_ABS   = 5'd2;
    localparam logic [4:0] ST_MUL   = 5'd3;
    localparam logic [4:0] ST_NUM   = 5'd4;
    localparam logic [4:0] ST_SAT   = 5'd5;
    localparam logic [4:0] ST_DIV   = 5'd6;
    localparam logic [4:0] ST_V_A10 = 5'd7;
    localparam logic [4:0] ST_V_B13 = 5'd8;
    localparam logic [4:0] ST_V_B14 = 5'd9;
    localparam logic [4:0] ST_V_HI  = 5'd10;
    localparam logic [4:0] ST_V_C7  = 5'd11;
    localparam logic [4:0] ST_V_LO  = 5'd12;
    localparam logic [4:0] ST_FIN   = 5'd13;
    localparam logic [4:0] ST_B_ADD = 5'd14;
    localparam logic [4:0] ST_B_SUB = 5'd15;
    localparam logic [4:0] ST_B_CLP = 5'd16;
    localparam logic [4:0] ST_DONE  = 5'd17;

    logic [4:0]       r_state;
    logic [31:0]      r_fullness;
    logic [5:0]       r_qp;
    logic [39:0]      r_last_sad;
    logic [39:0]      r_sad;
    logic [31:0]      r_bits;
    logic [ALU_W-1:0] r_acc;
    logic [ALU_W-1:0] r_aux;
    logic [38:0]      r_dsh;
    logic [2:0]       r_cnt;
    logic [7:0]       r_q;
    logic             r_neg;
    logic             r_vbr_up;
    logic             r_vbr_dn;

    logic [30:0]      w_half;
    logic [31:0]      w_den;
    logic             w_vbr_on;
    t_alu_req         w_req;
    t_alu_rsp         w_rsp;
    logic [4:0]       w_after_div;

    logic signed [10:0] w_adj;
    logic signed [10:0] w_delta;
    logic signed [10:0] w_step;
    logic signed [10:0] w_qp_raw;
    logic [5:0]         n_qp;

    assign w_half      = i_cfg.bucket_size[31:1];
    assign w_den       = {w_half, 1'b0};
    assign w_vbr_on    = (i_cfg.rc_mode == MODE_VBR) && (r_last_sad != 40'd0);
    assign w_after_div = w_vbr_on ? ST_V_A10 : ST_FIN;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_qp        = r_qp;
    assign o_level     = r_fullness;

    fqrc_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // Operand select for the shared unit.
    always_comb begin
        w_req = '0;
        unique case (r_state)
            ST_ERR: begin
                w_req.sub = 1'b1;
                w_req.a   = ALU_W'(r_fullness);
                w_req.b   = ALU_W'(w_half);
            end
            ST_ABS: begin
                w_req.sub = 1'b1;
                w_req.a   = ALU_W'(w_half);
                w_req.b   = ALU_W'(r_fullness);
            end
            ST_MUL: begin
                w_req.a = {r_acc[ALU_W-4:0], 3'b000};
                w_req.b = {r_acc[ALU_W-3:0], 2'b00};
            end
            ST_NUM: begin
                w_req.a = r_acc;
                w_req.b = ALU_W'(w_half);
            end
            ST_SAT: begin
                w_req.sub = 1'b1;
                w_req.a   = r_acc;
                w_req.b   = ALU_W'({w_den, 8'h00});
            end
            ST_DIV: begin
                w_req.sub = 1'b1;
                w_req.a   = r_acc;
                w_req.b   = ALU_W'(r_dsh);
            end
            ST_V_A10: begin
                w_req.a = ALU_W'({r_sad, 3'b000});
                w_req.b = ALU_W'({r_sad, 1'b0});
            end
            ST_V_B13: begin
                w_req.a = ALU_W'({r_last_sad, 3'b000});
                w_req.b = ALU_W'({r_last_sad, 2'b00});
            end
            ST_V_B14: begin
                w_req.a = r_acc;
                w_req.b = ALU_W'(r_last_sad);
            end
            ST_V_HI: begin
                w_req.sub = 1'b1;
                w_req.a   = r_acc;
                w_req.b   = r_aux;
            end
            ST_V_C7: begin
                w_req.sub = 1'b1;
                w_req.a   = ALU_W'({r_last_sad, 3'b000});
                w_req.b   = ALU_W'(r_last_sad);
            end
            ST_V_LO: begin
                w_req.sub = 1'b1;
                w_req.a   = r_aux;
                w_req.b   = r_acc;
            end
            ST_B_ADD: begin
                w_req.a = ALU_W'(r_fullness);
                w_req.b = ALU_W'(r_bits);
            end
            ST_B_SUB: begin
                w_req.sub = 1'b1;
                w_req.a   = r_acc;
                w_req.b   = ALU_W'(i_cfg.frame_budget);
            end
            ST_B_CLP: begin
                w_req.sub = 1'b1;
                w_req.a   = ALU_W'(i_cfg.bucket_size);
                w_req.b   = r_acc;
            end
            default: ;
        endcase
    end

    // Bounded step toward start_qp + adjust, then the QP clamps.
    always_comb begin
        w_adj = r_neg ? -$signed({3'b000, r_q}) : $signed({3'b000, r_q});
        if (r_vbr_up) begin
            w_adj = w_adj + 11'sd2;
        end else if (r_vbr_dn) begin
            w_adj = w_adj - 11'sd2;
        end
        w_step  = (i_cfg.rc_mode == MODE_LOW_LAT) ? STEP_LOW_LAT : STEP_NORMAL;
        w_delta = $signed({5'b0, i_cfg.start_qp}) + w_adj - $signed({5'b0, r_qp});
        if (w_delta > w_step) begin
            w_delta = w_step;
        end
        if (w_delta < -w_step) begin
            w_delta = -w_step;
        end
        w_qp_raw = $signed({5'b0, r_qp}) + w_delta;
        if (w_qp_raw < $signed({5'b0, i_cfg.lowest_qp})) begin
            w_qp_raw = $signed({5'b0, i_cfg.lowest_qp});
        end
        if (w_qp_raw > $signed({5'b0, i_cfg.highest_qp})) begin
            w_qp_raw = $signed({5'b0, i_cfg.highest_qp});
        end
        n_qp = w_qp_raw[5:0];
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        unique case (r_state) inside
            ST_IDLE: begin
                r_sad    <= i_sad;
                r_bits   <= i_bits;
                r_q      <= 8'h00;
                r_neg    <= 1'b0;
                r_vbr_up <= 1'b0;
                r_vbr_dn <= 1'b0;
            end
            ST_ERR: begin
                r_acc <= w_rsp.sum;
                r_neg <= !w_rsp.ge;
            end
            ST_ABS, ST_MUL, ST_NUM, ST_V_B13, ST_V_B14, ST_V_C7, ST_B_ADD: begin
                r_acc <= w_rsp.sum;
            end
            ST_SAT: begin
                r_dsh <= {w_den, 7'h00};
                r_cnt <= 3'd7;
                if (w_rsp.ge) begin
                    r_q <= 8'hFF;   // saturate: any |adjust| this large clamps
                end
            end
            ST_DIV: begin
                if (w_rsp.ge) begin
                    r_acc <= w_rsp.sum;
                end
                r_q   <= {r_q[6:0], w_rsp.ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 3'd1;
            end
            ST_V_A10: begin
                r_aux <= w_rsp.sum;
            end
            ST_V_HI: begin
                r_vbr_up <= !w_rsp.ge;
            end
            ST_V_LO: begin
                r_vbr_dn <= !w_rsp.ge;
            end
            ST_B_SUB: begin
                r_acc <= w_rsp.ge ? w_rsp.sum : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fullness <= RST_FULLNESS;
            r_qp       <= RST_QP;
            r_last_sad <= 40'd0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_reload) begin
                        r_fullness <= i_reload_level;
                    end
                    if (i_in_valid) begin
                        if (i_op == OP_REPORT_BITS) begin
                            r_state <= ST_B_ADD;
                        end else if (w_half == 31'd0) begin
                            r_state <= w_after_div;
                        end else begin
                            r_state <= ST_ERR;
                        end
                    end
                end
                ST_ERR:   r_state <= w_rsp.ge ? ST_MUL : ST_ABS;
                ST_ABS:   r_state <= ST_MUL;
                ST_MUL:   r_state <= ST_NUM;
                ST_NUM:   r_state <= ST_SAT;
                ST_SAT:   r_state <= w_rsp.ge ? w_after_div : ST_DIV;
                ST_DIV: begin
                    if (r_cnt == 3'd0) begin
                        r_state <= w_after_div;
                    end
                end
                ST_V_A10: r_state <= ST_V_B13;
                ST_V_B13: r_state <= ST_V_B14;
                ST_V_B14: r_state <= ST_V_HI;
                ST_V_HI:  r_state <= w_rsp.ge ? ST_V_C7 : ST_FIN;
                ST_V_C7:  r_state <= ST_V_LO;
                ST_V_LO:  r_state <= ST_FIN;
                ST_FIN: begin
                    r_qp       <= n_qp;
                    r_last_sad <= r_sad;
                    r_state    <= ST_DONE;
                end
                ST_B_ADD: r_state <= ST_B_SUB;
                ST_B_SUB: r_state <= ST_B_CLP;
                ST_B_CLP: begin
                    r_fullness <= w_rsp.ge ? r_acc[31:0] : i_cfg.bucket_size;
                    r_state    <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* design/frame_qp_rate_controller_top.sv */
// Steps: a bits report adds the frame bits, subtracts the frame budget and clamps to the
// bucket size; a QP request runs error, magnitude, scale, saturation check, 8 restoring
// divide steps and up to 6 VBR compare steps, all on one shared 46-bit add/subtract unit;
// an empty half bucket skips straight to the VBR steps or the QP update.
// Throughput: one item at a time; the input is not ready until the sequencer is idle, but
// a finished result waits in the output register while the next item is taken.
// Reset: synchronous active-low i_rst_n loads the register defaults and bucket state.
`default_nettype none
module frame_qp_rate_controller_top
    import fqrc_pkg::*;
(
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    // Configuration write port
    input  var logic        i_cfg_we,
    input  var logic [2:0]  i_cfg_idx,
    input  var logic [31:0] i_cfg_data,
    // Input stream
    input  var logic        s_axis_tvalid,
    output logic            s_axis_tready,
    input  var logic [71:0] s_axis_tdata,   // [39:0] frame_sad, [71:40] frame_bits
    input  var logic [0:0]  s_axis_tuser,   // [0] operation
    // Result stream
    output logic            m_axis_tvalid,
    input  var logic        m_axis_tready,
    output logic [39:0]     m_axis_tdata    // [5:0] frame_qp, [37:6] bucket_level, [39:38] 0
);

    t_cfg        r_cfg;
    logic        r_m_valid;
    logic [5:0]  r_m_qp;
    logic [31:0] r_m_level;

    logic        w_reload;
    logic        w_res_valid;
    logic        w_res_ready;
    logic [5:0]  w_qp;
    logic [31:0] w_level;

    // Register writes. A bucket_size write also reloads fullness to half (in the core, only while it is idle).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rc_mode      <= RST_RC_MODE;
            r_cfg.bucket_size  <= RST_BUCKET_SIZE;
            r_cfg.frame_budget <= RST_FRAME_BUDGET;
            r_cfg.start_qp     <= RST_START_QP;
            r_cfg.lowest_qp    <= RST_LOWEST_QP;
            r_cfg.highest_qp   <= RST_HIGHEST_QP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RC_MODE:      r_cfg.rc_mode      <= i_cfg_data[1:0];
                CFG_BUCKET_SIZE:  r_cfg.bucket_size  <= i_cfg_data;
                CFG_FRAME_BUDGET: r_cfg.frame_budget <= i_cfg_data;
                CFG_START_QP:     r_cfg.start_qp     <= i_cfg_data[5:0];
                CFG_LOWEST_QP:    r_cfg.lowest_qp    <= i_cfg_data[5:0];
                CFG_HIGHEST_QP:   r_cfg.highest_qp   <= i_cfg_data[5:0];
                default: ;        // drop writes beyond the register list
            endcase
        end
    end

    assign w_reload = i_cfg_we && (i_cfg_idx == CFG_BUCKET_SIZE);

    fqrc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_reload       (w_reload),
        .i_reload_level ({1'b0, i_cfg_data[31:1]}),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_op           (s_axis_tuser[0]),
        .i_sad          (s_axis_tdata[39:0]),
        .i_bits         (s_axis_tdata[71:40]),
        .o_res_valid    (w_res_valid),
        .i_res_ready    (w_res_ready),
        .o_qp           (w_qp),
        .o_level        (w_level)
    );

    // Output register: take a new result when empty or when the current one transfers.
    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_m_qp    <= w_qp;
            r_m_level <= w_level;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_level, r_m_qp};

`ifndef SYNTH
    // The sequencer holds off input in the cycle after taking an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // A result handed from the core always shows up on the output.
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_ready) |=> m_axis_tvalid)
        else $error("core result lost at output register");

    // Checks that the reported bucket level never exceeds the bucket capacity.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[37:6] <= r_cfg.bucket_size))
        else $error("bucket level above capacity");
`endif

endmodule
`default_nettype wire
